// ===== sv/sfr_pkg.sv =====
// Shared types and constants of the stream find-and-replace block.
package sfr_pkg;

  localparam int MAX_PATTERN_DEF = 16;
  localparam int MAX_REPLACE_DEF = 16;

  // Byte lanes held by the two 64-bit halves of the pattern and replacement registers.
  localparam int BYTE_LANES = 16;
  localparam int LEN_W      = 5;
  localparam int CFG_W      = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int FUNC_W     = 2;

  localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_DATA       = 2'd0,
    FUNC_SEG_END    = 2'd1,
    FUNC_STREAM_END = 2'd2
  } sfr_func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAT_LEN = 3'd0,
    REG_PAT_LO  = 3'd1,
    REG_PAT_HI  = 3'd2,
    REG_REP_LEN = 3'd3,
    REG_REP_LO  = 3'd4,
    REG_REP_HI  = 3'd5
  } sfr_reg_e;

  typedef struct packed {
    logic load;
    logic shift_emit;
    logic rep_start;
    logic rep_emit;
    logic nl_emit;
    logic finish;
  } sfr_cmd_t;

  typedef struct packed {
    logic match;
    logic full;
    logic cnt_zero;
    logic emit_ok;
    logic rep_done;
  } sfr_status_t;

endpackage

// ===== sv/sfr_datapath.sv =====
// Datapath: configuration registers, hold window, prefix matcher and output word registers.
module sfr_datapath #(
  parameter int MAX_PATTERN = sfr_pkg::MAX_PATTERN_DEF,
  parameter int MAX_REPLACE = sfr_pkg::MAX_REPLACE_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  input  logic [sfr_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [sfr_pkg::CFG_W-1:0]    cfg_data_i,
  input  logic [7:0]                   data_byte_i,
  input  sfr_pkg::sfr_cmd_t            cmd_i,
  output sfr_pkg::sfr_status_t         status_o,
  input  logic                         out_stall_i,
  output logic                         out_valid_o,
  output logic [7:0]                   out_byte_o,
  output logic                         last_o
);
  import sfr_pkg::*;

  localparam int CW = $clog2(MAX_PATTERN + 1);
  localparam int BI = $clog2(MAX_PATTERN);
  localparam int RW = $clog2(MAX_REPLACE + 1);

  logic [LEN_W-1:0] plen_q, rlen_q;
  logic [CFG_W-1:0] pat_lo_q, pat_hi_q, rep_lo_q, rep_hi_q;
  logic [8*BYTE_LANES-1:0] pat_all, rep_all;

  logic [7:0]    win_q [MAX_PATTERN];
  logic [CW-1:0] cnt_q;
  logic [RW-1:0] ridx_q;
  logic [CW-1:0] eff_plen;
  logic [RW-1:0] eff_rlen;

  logic [MAX_PATTERN-1:0] lane_ok;
  logic       emit, push, out_free;
  logic [7:0] emit_byte;
  logic       pend_valid_q;
  logic [7:0] pend_byte_q;
  logic       out_valid_q, out_last_q;
  logic [7:0] out_byte_q;

  // A length of zero counts as one; anything above the window size saturates.
  function automatic logic [CW-1:0] eff_plen_f(input logic [LEN_W-1:0] v);
    logic [CW-1:0] r;
    if (v == '0) begin
      r = CW'(1);
    end else if (v > LEN_W'(MAX_PATTERN)) begin
      r = CW'(MAX_PATTERN);
    end else begin
      r = CW'(v);
    end
    return r;
  endfunction

  assign pat_all  = {pat_hi_q, pat_lo_q};
  assign rep_all  = {rep_hi_q, rep_lo_q};
  assign eff_plen = eff_plen_f(plen_q);
  assign eff_rlen = (rlen_q > LEN_W'(MAX_REPLACE)) ? RW'(MAX_REPLACE) : RW'(rlen_q);

  // The window head is kept when every held byte agrees with the pattern prefix.
  for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_lane
    assign lane_ok[j] = (CW'(j) >= cnt_q) ||
                        ((CW'(j) < eff_plen) && (win_q[j] == pat_all[8*j +: 8]));
  end

  assign status_o.match    = &lane_ok;
  assign status_o.full     = (&lane_ok) && (cnt_q == eff_plen);
  assign status_o.cnt_zero = (cnt_q == '0);
  assign status_o.rep_done = (ridx_q == eff_rlen);

  assign out_free          = !out_valid_q || !out_stall_i;
  assign status_o.emit_ok  = !pend_valid_q || out_free;

  assign emit = cmd_i.shift_emit || cmd_i.rep_emit || cmd_i.nl_emit;
  assign push = (emit || cmd_i.finish) && pend_valid_q;

  always_comb begin
    emit_byte = NEWLINE_BYTE;
    if (cmd_i.shift_emit) begin
      emit_byte = win_q[0];
    end else if (cmd_i.rep_emit) begin
      emit_byte = rep_all[{4'(ridx_q), 3'b000} +: 8];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plen_q   <= LEN_W'(1);
      rlen_q   <= '0;
      pat_lo_q <= '0;
      pat_hi_q <= '0;
      rep_lo_q <= '0;
      rep_hi_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_PAT_LEN: plen_q   <= cfg_data_i[LEN_W-1:0];
        REG_PAT_LO:  pat_lo_q <= cfg_data_i;
        REG_PAT_HI:  pat_hi_q <= cfg_data_i;
        REG_REP_LEN: rlen_q   <= cfg_data_i[LEN_W-1:0];
        REG_REP_LO:  rep_lo_q <= cfg_data_i;
        REG_REP_HI:  rep_hi_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      ridx_q <= '0;
    end else begin
      if (cmd_i.load) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (cmd_i.shift_emit) begin
        cnt_q <= cnt_q - CW'(1);
      end else if (cmd_i.rep_start) begin
        cnt_q <= '0;
      end else if (cfg_valid_i && (cfg_index_i == REG_PAT_LEN) &&
                   (cnt_q >= eff_plen_f(cfg_data_i[LEN_W-1:0]))) begin
        // A shorter pattern drops a partial match that no longer fits.
        cnt_q <= '0;
      end
      if (cmd_i.rep_start) begin
        ridx_q <= '0;
      end else if (cmd_i.rep_emit) begin
        ridx_q <= ridx_q + RW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      win_q[cnt_q[BI-1:0]] <= data_byte_i;
    end else if (cmd_i.shift_emit) begin
      for (int i = 0; i < MAX_PATTERN - 1; i++) begin
        win_q[i] <= win_q[i+1];
      end
    end
  end

  // One word waits in a pending slot until it is known whether it ends the item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (emit) begin
        pend_valid_q <= 1'b1;
      end else if (cmd_i.finish) begin
        pend_valid_q <= 1'b0;
      end
      out_valid_q <= push || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      pend_byte_q <= emit_byte;
    end
    if (push) begin
      out_byte_q <= pend_byte_q;
      out_last_q <= cmd_i.finish;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign last_o      = out_last_q;

endmodule

// ===== sv/sfr_ctrl.sv =====
// Controller state machine that sequences scanning, replacement and flushing per input word.
module sfr_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic [sfr_pkg::FUNC_W-1:0] func_i,
  output logic                       in_stall_o,
  input  sfr_pkg::sfr_status_t       status_i,
  output sfr_pkg::sfr_cmd_t          cmd_o
);
  import sfr_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_REPL,
    ST_FLUSH,
    ST_NEWLINE,
    ST_FIN
  } state_e;

  state_e   state_q, state_d;
  logic     nl_q, nl_d;
  logic     stall_q;
  sfr_cmd_t cmd;

  always_comb begin
    cmd     = '0;
    state_d = state_q;
    nl_d    = nl_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (func_i)
            FUNC_DATA: begin
              cmd.load = 1'b1;
              state_d  = ST_SCAN;
            end
            FUNC_SEG_END: begin
              nl_d    = 1'b1;
              state_d = ST_FLUSH;
            end
            FUNC_STREAM_END: begin
              nl_d    = 1'b0;
              state_d = ST_FLUSH;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        // Each failed test releases the window head once the output can take it and retries one byte later.
        if (status_i.match) begin
          if (status_i.full) begin
            cmd.rep_start = 1'b1;
            state_d       = ST_REPL;
          end else begin
            state_d = ST_FIN;
          end
        end else if (status_i.emit_ok) begin
          cmd.shift_emit = 1'b1;
        end
      end
      ST_REPL: begin
        if (status_i.rep_done) begin
          state_d = ST_FIN;
        end else if (status_i.emit_ok) begin
          cmd.rep_emit = 1'b1;
        end
      end
      ST_FLUSH: begin
        if (status_i.cnt_zero) begin
          state_d = nl_q ? ST_NEWLINE : ST_FIN;
        end else if (status_i.emit_ok) begin
          cmd.shift_emit = 1'b1;
        end
      end
      ST_NEWLINE: begin
        if (status_i.emit_ok) begin
          cmd.nl_emit = 1'b1;
          state_d     = ST_FIN;
        end
      end
      ST_FIN: begin
        if (status_i.emit_ok) begin
          cmd.finish = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      nl_q    <= 1'b0;
      stall_q <= 1'b0;
    end else begin
      state_q <= state_d;
      nl_q    <= nl_d;
      stall_q <= (state_d != ST_IDLE);
    end
  end

  assign in_stall_o = stall_q;
  assign cmd_o      = cmd;

endmodule

// ===== sv/stream_find_replace.sv =====
// Top level of the streaming find-and-replace block.
//
// Input words carry func_i and data_byte_i; a word is taken when in_valid_i is high
// and in_stall_o is low. Output words carry out_byte_o and last_o, which marks the
// final word produced by one input word; the receiver holds them with out_stall_i.
// Registers are written through cfg_valid_i, cfg_index_i and cfg_data_i; the user
// must write them only while the block is idle, which the block itself does not
// enforce; cfg_ready_o is always high. One input word is processed at a time. A data
// byte is loaded, then tested once per released byte plus a final test, and then the
// word is closed; a full match emits the replacement bytes before the close. A flush
// emits the held bytes, then the newline for a segment end, and then closes the word.
// One word leaves per cycle while out_stall_i is low, so the shared output port sets
// the pace for long replacements and flushes. Each released byte waits in a pending
// slot until the next one or the close before it passes to the output register.
// When the receiver stalls, the output register holds and the sequencer waits;
// in_stall_o stays high until the current input word is fully handled.
// Reset empties the hold window, restores pattern length one with all other
// registers zero, and leaves the block ready for a new input word.
module stream_find_replace #(
  parameter int MAX_PATTERN = sfr_pkg::MAX_PATTERN_DEF,
  parameter int MAX_REPLACE = sfr_pkg::MAX_REPLACE_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [sfr_pkg::FUNC_W-1:0]    func_i,
  input  logic [7:0]                    data_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [7:0]                    out_byte_o,
  output logic                          last_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [sfr_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [sfr_pkg::CFG_W-1:0]     cfg_data_i
);
  import sfr_pkg::*;

  sfr_cmd_t    cmd;
  sfr_status_t status;

  assign cfg_ready_o = 1'b1;

  sfr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .func_i     (func_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  sfr_datapath #(
    .MAX_PATTERN (MAX_PATTERN),
    .MAX_REPLACE (MAX_REPLACE)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .data_byte_i (data_byte_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_byte_o  (out_byte_o),
    .last_o      (last_o)
  );

endmodule

// ===== tb/sfr_checker.sv =====
// Checker for the stream find-and-replace block: predicts every output word and compares.
module sfr_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic [sfr_pkg::FUNC_W-1:0]    func_i,
  input  logic [7:0]                    data_byte_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic [7:0]                    out_byte_i,
  input  logic                          last_i,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [sfr_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [sfr_pkg::CFG_W-1:0]     cfg_data_i,
  output int                            fail_count_o,
  output int                            pending_o
);
  import sfr_pkg::*;

  localparam int HOLD_DEPTH = MAX_PATTERN_DEF - 1;
  localparam int REPORT_CAP = 40;

  typedef struct {
    logic [7:0] value;
    logic       last;
  } out_word_t;

  out_word_t   rewritten_q [$];
  logic [4:0]  pat_len_q;
  logic [4:0]  rep_len_q;
  logic [63:0] pat_lo_q;
  logic [63:0] pat_hi_q;
  logic [63:0] rep_lo_q;
  logic [63:0] rep_hi_q;
  logic [7:0]  hold_win [HOLD_DEPTH];
  int          held_cnt;
  int          out_seen;

  function automatic int pattern_span(input logic [4:0] len);
    if (len == 5'd0) return 1;
    if (int'(len) > MAX_PATTERN_DEF) return MAX_PATTERN_DEF;
    return int'(len);
  endfunction

  function automatic int replace_span(input logic [4:0] len);
    if (int'(len) > MAX_REPLACE_DEF) return MAX_REPLACE_DEF;
    return int'(len);
  endfunction

  function automatic logic [7:0] lane_of(input logic [63:0] lo, input logic [63:0] hi,
                                         input int idx);
    int k;
    k = idx & 15;
    if (k < 8) return lo[8*k +: 8];
    return hi[8*(k-8) +: 8];
  endfunction

  task automatic report_mismatch(input string what);
    if (fail_count_o < REPORT_CAP) $display("mismatch: %s", what);
    fail_count_o++;
  endtask

  task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    case (idx)
      REG_PAT_LEN: begin
        pat_len_q = val[4:0];
        // A shorter pattern that no longer fits the held bytes drops them.
        if (held_cnt >= pattern_span(pat_len_q)) held_cnt = 0;
      end
      REG_PAT_LO:  pat_lo_q = val;
      REG_PAT_HI:  pat_hi_q = val;
      REG_REP_LEN: rep_len_q = val[4:0];
      REG_REP_LO:  rep_lo_q = val;
      REG_REP_HI:  rep_hi_q = val;
      default: ;
    endcase
  endtask

  task automatic rewrite_word(input logic [FUNC_W-1:0] fn, input logic [7:0] din);
    logic [7:0] scan [MAX_PATTERN_DEF];
    logic [7:0] emit_q [$];
    out_word_t  w;
    int         m, n, s, j, p, r;
    bit         ok;
    if (fn == FUNC_SEG_END || fn == FUNC_STREAM_END) begin
      for (j = 0; j < held_cnt; j++) emit_q.push_back(hold_win[j]);
      held_cnt = 0;
      if (fn == FUNC_SEG_END) emit_q.push_back(NEWLINE_BYTE);
    end else if (fn == FUNC_DATA) begin
      p = pattern_span(pat_len_q);
      m = held_cnt;
      for (j = 0; j < m; j++) scan[j] = hold_win[j];
      scan[m] = din;
      n = m + 1;
      // Find the earliest start whose tail is still a prefix of the pattern.
      for (s = 0; s < n; s++) begin
        ok = 1'b1;
        for (j = 0; s + j < n; j++) begin
          if (j >= p || scan[s+j] != lane_of(pat_lo_q, pat_hi_q, j)) begin
            ok = 1'b0;
            break;
          end
        end
        if (ok) break;
      end
      if (s == 0 && n == p) begin
        r = replace_span(rep_len_q);
        for (j = 0; j < r; j++) emit_q.push_back(lane_of(rep_lo_q, rep_hi_q, j));
        held_cnt = 0;
      end else begin
        for (j = 0; j < s; j++) emit_q.push_back(scan[j]);
        for (j = s; j < n; j++) hold_win[j-s] = scan[j];
        held_cnt = n - s;
      end
    end
    for (j = 0; j < emit_q.size(); j++) begin
      w.value = emit_q[j];
      w.last  = (j == emit_q.size() - 1);
      rewritten_q.push_back(w);
    end
  endtask

  task automatic check_word(input logic [7:0] got_byte, input logic got_last);
    out_word_t want;
    if (rewritten_q.size() == 0) begin
      report_mismatch($sformatf("out word %0d: none expected, got %02h", out_seen, got_byte));
    end else begin
      want = rewritten_q.pop_front();
      if (got_byte !== want.value)
        report_mismatch($sformatf("out word %0d: byte %02h, want %02h",
                                  out_seen, got_byte, want.value));
      if (got_last !== want.last)
        report_mismatch($sformatf("out word %0d: last %b, want %b",
                                  out_seen, got_last, want.last));
    end
    out_seen++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_len_q    = 5'd1;
      rep_len_q    = 5'd0;
      pat_lo_q     = '0;
      pat_hi_q     = '0;
      rep_lo_q     = '0;
      rep_hi_q     = '0;
      held_cnt     = 0;
      out_seen     = 0;
      fail_count_o = 0;
      rewritten_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) apply_reg(cfg_index_i, cfg_data_i);
      if (in_valid_i && !in_stall_i) rewrite_word(func_i, data_byte_i);
      if (out_valid_i && !out_stall_i) check_word(out_byte_i, last_i);
      pending_o <= rewritten_q.size();
    end
  end

endmodule

// ===== tb/tb_stream_find_replace.sv =====
// Testbench top for the stream find-and-replace block: stimulus, stalls and verdict.
module tb_stream_find_replace;
  import sfr_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int LIMIT_CYCLES  = 1_000_000;
  localparam int SETTLE_CYCLES = 40;
  localparam int LONG_HOLD     = 300;
  localparam int PHASES        = 8;
  localparam int PHASE_WORDS   = 25;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [FUNC_W-1:0]    func;
  logic [7:0]           data_byte;
  logic                 out_valid;
  logic                 out_stall;
  logic [7:0]           out_byte;
  logic                 last;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  int                   fail_count;
  int                   pending;

  int         hold_req_cnt = 0;
  bit         quiet = 1'b0;
  logic [7:0] pat_mem [16];
  logic [7:0] alpha [3];
  int         alpha_n = 2;
  int         pat_span = 1;

  stream_find_replace dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .func_i      (func),
    .data_byte_i (data_byte),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_byte_o  (out_byte),
    .last_o      (last),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  sfr_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .func_i       (func),
    .data_byte_i  (data_byte),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_byte_i   (out_byte),
    .last_i       (last),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("== FAIL ==");
    $finish;
  end

  // Receiver: random stall runs, one long hold-off on request, none while quiet.
  initial begin : receiver
    int hold_seen;
    int run;
    bit stall_v;
    hold_seen = 0;
    out_stall = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_seen != hold_req_cnt) begin
        hold_seen = hold_req_cnt;
        stall_v   = 1'b1;
        run       = LONG_HOLD;
      end else if (quiet) begin
        stall_v = 1'b0;
        run     = 1;
      end else begin
        stall_v = ($urandom_range(0, 99) < 40);
        run     = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(8, 30);
      end
      out_stall <= stall_v;
      repeat (run) @(posedge clk);
    end
  end

  function automatic logic [7:0] alpha_pick();
    return alpha[$urandom_range(0, alpha_n - 1)];
  endfunction

  function automatic logic [CFG_W-1:0] len_word(input int raw);
    logic [CFG_W-1:0] v;
    v = $urandom_range(0, 1) ? {$urandom, $urandom} : '0;
    v[4:0] = raw[4:0];
    return v;
  endfunction

  // Offers one word, waits until it is taken, then leaves a random gap.
  task automatic send_word(input logic [FUNC_W-1:0] fn, input logic [7:0] b);
    int gap;
    int r;
    in_valid  <= 1'b1;
    func      <= fn;
    data_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (quiet) begin
      gap = 0;
    end else begin
      r   = $urandom_range(0, 99);
      gap = (r < 70) ? 0 : (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_reg(input sfr_reg_e idx, input logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Stops offering words and waits until every expected word is out and the block is done.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    int          ph, plen, rlen, left, k, r, i;
    bit          with_hold, hold_fired;
    logic [7:0]  b;
    logic [63:0] lo, hi;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    func      = FUNC_DATA;
    data_byte = 8'h00;
    cfg_valid = 1'b0;
    cfg_index = REG_PAT_LEN;
    cfg_data  = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: the pattern is one zero byte and the replacement is empty.
    send_word(FUNC_DATA, 8'h00);
    send_word(FUNC_DATA, 8'hFF);
    send_word(FUNC_DATA, 8'h00);
    send_word(FUNC_SEG_END, 8'hA5);
    send_word(FUNC_STREAM_END, 8'h5A);
    send_word(FUNC_UNUSED, 8'hC3);

    // Pattern "aab": a failed partial prefix must still find the later match.
    settle();
    write_reg(REG_PAT_LEN, 64'd3);
    write_reg(REG_PAT_LO, 64'h0000_0000_0062_6161);
    write_reg(REG_PAT_HI, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_REP_LEN, 64'd2);
    write_reg(REG_REP_LO, 64'h0000_0000_0000_5958);
    write_reg(REG_REP_HI, 64'h0123_4567_89AB_CDEF);
    send_word(FUNC_DATA, 8'h61);
    send_word(FUNC_DATA, 8'h61);
    send_word(FUNC_DATA, 8'h61);
    send_word(FUNC_DATA, 8'h62);
    send_word(FUNC_DATA, 8'h61);
    send_word(FUNC_DATA, 8'h61);
    // Pattern bytes change while two bytes are held; they are rechecked on the next byte.
    settle();
    write_reg(REG_PAT_LO, 64'h0000_0000_0063_6161);
    send_word(FUNC_DATA, 8'h63);
    send_word(FUNC_DATA, 8'h61);
    send_word(FUNC_DATA, 8'h61);
    send_word(FUNC_STREAM_END, 8'hFF);
    send_word(FUNC_DATA, 8'h61);
    send_word(FUNC_SEG_END, 8'h00);

    // Zero pattern length acts as one; an oversized replacement length saturates.
    settle();
    write_reg(REG_PAT_LEN, 64'd0);
    write_reg(REG_PAT_LO, 64'h0000_0000_0000_0071);
    write_reg(REG_REP_LEN, 64'd31);
    write_reg(REG_REP_LO, {$urandom, $urandom});
    write_reg(REG_REP_HI, {$urandom, $urandom});
    send_word(FUNC_DATA, 8'h71);
    send_word(FUNC_DATA, 8'h7A);

    // Oversized pattern length saturates; shortening it below the held count drops the bytes.
    settle();
    write_reg(REG_PAT_LEN, 64'd20);
    write_reg(REG_PAT_LO, 64'h4141_4141_4141_4141);
    write_reg(REG_PAT_HI, 64'h4141_4141_4141_4141);
    send_word(FUNC_DATA, 8'h41);
    send_word(FUNC_DATA, 8'h41);
    send_word(FUNC_DATA, 8'h41);
    settle();
    write_reg(REG_PAT_LEN, 64'd2);
    send_word(FUNC_DATA, 8'h42);
    send_word(FUNC_SEG_END, 8'h0F);

    // Random phases: mostly pattern prefixes and bytes from a small alphabet.
    for (ph = 0; ph < PHASES; ph++) begin
      with_hold = 1'b0;
      alpha_n   = 2;
      case (ph)
        0: begin plen = 3; rlen = 2; end
        1: begin plen = 2; rlen = 0; with_hold = 1'b1; end
        2: begin plen = 16; rlen = 16; end
        3: begin plen = 1; rlen = 16; alpha_n = 3; end
        4: begin plen = 31; rlen = 31; end
        5: begin plen = $urandom_range(1, 16); rlen = $urandom_range(0, 16); alpha_n = 3; end
        6: begin plen = 0; rlen = 1; end
        default: begin plen = $urandom_range(4, 8); rlen = $urandom_range(0, 20); end
      endcase
      settle();
      quiet <= (ph == 3);
      for (i = 0; i < 3; i++) alpha[i] = 8'($urandom_range(0, 255));
      pat_span = (plen == 0) ? 1 : (plen > 16) ? 16 : plen;
      for (i = 0; i < 16; i++)
        pat_mem[i] = (i < pat_span) ? alpha_pick() : 8'($urandom_range(0, 255));
      for (i = 0; i < 8; i++) begin
        lo[8*i +: 8] = pat_mem[i];
        hi[8*i +: 8] = pat_mem[i+8];
      end
      write_reg(REG_REP_LEN, len_word(rlen));
      write_reg(REG_REP_LO, {$urandom, $urandom});
      write_reg(REG_REP_HI, {$urandom, $urandom});
      write_reg(REG_PAT_LEN, len_word(plen));
      write_reg(REG_PAT_LO, lo);
      write_reg(REG_PAT_HI, hi);

      left       = PHASE_WORDS;
      hold_fired = 1'b0;
      while (left > 0) begin
        // The receiver holds off for a long stretch while words keep coming.
        if (with_hold && !hold_fired && left < PHASE_WORDS - 5) begin
          hold_req_cnt <= hold_req_cnt + 1;
          hold_fired = 1'b1;
        end
        r = $urandom_range(0, 99);
        if (r < 45) begin
          k = $urandom_range(1, pat_span);
          for (i = 0; i < k; i++) begin
            b = pat_mem[i];
            if (i == k - 1 && $urandom_range(0, 3) == 0) b = alpha_pick();
            send_word(FUNC_DATA, b);
          end
          left -= k;
        end else if (r < 78) begin
          send_word(FUNC_DATA, alpha_pick());
          left--;
        end else if (r < 88) begin
          send_word(FUNC_DATA, 8'($urandom_range(0, 255)));
          left--;
        end else if (r < 94) begin
          send_word(FUNC_SEG_END, 8'($urandom_range(0, 255)));
          left--;
        end else if (r < 98) begin
          send_word(FUNC_STREAM_END, 8'($urandom_range(0, 255)));
          left--;
        end else begin
          send_word(FUNC_UNUSED, 8'($urandom_range(0, 255)));
        end
      end
    end

    settle();
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
